// ----- rtl/core/tcc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console cursor and scroll block.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 32;

	localparam int CHAR_W       = 8;
	localparam int SLOT_PORT_W  = 6;
	localparam int COL_PORT_W   = 7;
	localparam int GLYPH_W      = 8;

	localparam logic CMD_DRAW   = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h0A;
	localparam logic [CHAR_W-1:0] CTRL_LOW_MAX   = 8'h1F;
	localparam logic [CHAR_W-1:0] CTRL_HIGH_MIN  = 8'h7F;
	localparam logic [CHAR_W-1:0] CTRL_HIGH_MAX  = 8'h9F;
	localparam logic [CHAR_W-1:0] GLYPH_OFFSET   = 8'd32;

	typedef struct packed {
		logic                   command;
		logic [SLOT_PORT_W-1:0] row_slot;
		logic [COL_PORT_W-1:0]  column;
		logic [GLYPH_W-1:0]     glyph_index;
		logic [SLOT_PORT_W-1:0] top_slot;
		logic                   last;
	} cmd_t;

	// up to two commands caused by one byte, in delivery order
	typedef struct packed {
		logic valid0;
		cmd_t cmd0;
		logic valid1;
		cmd_t cmd1;
	} cmd_pair_t;

endpackage
`default_nettype wire

// ----- rtl/core/tcc_cursor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_cursor
// Cursor and ring base registers; decodes one byte into its commands.
// ----------------------------------------------------------------------------
module tcc_cursor import tcc_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [CHAR_W-1:0] char_code,
	output cmd_pair_t              cmds
);

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int SLOT_W = $clog2(ROWS + 1);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] base_q;

	logic              is_ctrl, is_lf, printable;
	logic              bottom, wraps, new_line, scroll;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] slot_cur, base_next;
	cmd_t              draw_cmd, clear_cmd;

	always_comb begin
		is_ctrl   = (char_code <= CTRL_LOW_MAX) ||
		            ((char_code >= CTRL_HIGH_MIN) && (char_code <= CTRL_HIGH_MAX));
		is_lf     = (char_code == CHAR_LF);
		printable = !is_ctrl;
		bottom    = (row_q == ROW_W'(ROWS - 1));
		wraps     = (col_q == COL_W'(COLUMNS - 1));
		new_line  = is_lf || (printable && wraps);
		scroll    = new_line && bottom;

		// screen row -> physical slot, mod ROWS+1
		slot_sum  = {1'b0, base_q} + (SLOT_W+1)'(row_q);
		if (slot_sum >= (SLOT_W+1)'(ROWS + 1)) begin
			slot_sum = slot_sum - (SLOT_W+1)'(ROWS + 1);
		end
		slot_cur  = slot_sum[SLOT_W-1:0];
		base_next = (base_q == SLOT_W'(ROWS)) ? '0 : base_q + 1'b1;

		draw_cmd.command     = CMD_DRAW;
		draw_cmd.row_slot    = SLOT_PORT_W'(slot_cur);
		draw_cmd.column      = COL_PORT_W'(col_q);
		draw_cmd.glyph_index = char_code - GLYPH_OFFSET;
		draw_cmd.top_slot    = SLOT_PORT_W'(base_q);
		draw_cmd.last        = !scroll;

		clear_cmd.command     = CMD_CLEAR;
		clear_cmd.row_slot    = SLOT_PORT_W'(base_q);
		clear_cmd.column      = '0;
		clear_cmd.glyph_index = '0;
		clear_cmd.top_slot    = SLOT_PORT_W'(base_next);
		clear_cmd.last        = 1'b1;

		cmds.valid0 = printable || (is_lf && bottom);
		cmds.cmd0   = printable ? draw_cmd : clear_cmd;
		cmds.valid1 = printable && scroll;
		cmds.cmd1   = clear_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			base_q <= '0;
		end else if (step && (printable || is_lf)) begin
			if (new_line) begin
				col_q <= '0;
				if (bottom) begin
					base_q <= base_next;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/tcc_out_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_out_queue
// Result register plus one holding slot for the second command of a byte.
// ----------------------------------------------------------------------------
module tcc_out_queue import tcc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire cmd_pair_t cmds,
	output logic           can_take,
	output logic           out_valid,
	input  wire logic      out_ready,
	output cmd_t           out_cmd
);

	logic out_valid_q, pend_valid_q;
	cmd_t out_q, pend_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign can_take  = !pend_valid_q && out_free;
	assign out_valid = out_valid_q;
	assign out_cmd   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (cmds.valid0) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			pend_valid_q <= cmds.valid1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q) begin
			if (out_free) begin
				out_q <= pend_q;
			end
		end else if (push && cmds.valid0) begin
			out_q  <= cmds.cmd0;
			pend_q <= cmds.cmd1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/text_console_cursor_scroll.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Cursor and scroll control of a text console: bytes in, draw/clear commands out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, char_code) takes one byte per transfer.
//   Output channel (out_valid/out_ready) moves one command per transfer:
//   draw glyph at (row_slot, column) or clear row slot, with top_slot and
//   last (final command of the byte).
//   Path: a taken byte lands in the input register, is decoded once the output
//   side can take both its commands, and its first command is registered.
//   Throughput, set by the result register and its one-entry holding slot:
//   one byte per cycle for bytes with zero or one command while out_ready
//   is high; a printable byte that fills the bottom line gives draw then
//   clear, and the next byte is decoded only once the clear has left the slot.
//   Ignored control bytes still pass through the input register but
//   produce no transfer.
//   Reset (arst_n low) homes the cursor to column 0, row 0, ring base 0 and
//   drops everything in flight.
//   When out_ready is low, the result register holds; the input register
//   still fills, then in_ready drops until the output frees up.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll import tcc_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [CHAR_W-1:0]      char_code,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        command,
	output logic [SLOT_PORT_W-1:0]      row_slot,
	output logic [COL_PORT_W-1:0]       column,
	output logic [GLYPH_W-1:0]          glyph_index,
	output logic [SLOT_PORT_W-1:0]      top_slot,
	output logic                        last
);

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;

	logic      can_take, step;
	cmd_pair_t cmds;
	cmd_t      out_cmd;

	// decode the staged byte whenever the output side can absorb both commands
	assign step     = valid_s1 && can_take;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
		end
	end

	tcc_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.char_code(char_s1),
		.cmds     (cmds)
	);

	tcc_out_queue u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (step),
		.cmds     (cmds),
		.can_take (can_take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_cmd  (out_cmd)
	);

	assign command     = out_cmd.command;
	assign row_slot    = out_cmd.row_slot;
	assign column      = out_cmd.column;
	assign glyph_index = out_cmd.glyph_index;
	assign top_slot    = out_cmd.top_slot;
	assign last        = out_cmd.last;

endmodule
`default_nettype wire

// ----- rtl/core/tcc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks of the console command stream, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_checker import tcc_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic                   command,
	input wire logic [COL_PORT_W-1:0]  column,
	input wire logic [GLYPH_W-1:0]     glyph_index,
	input wire logic                   last
);

	// stalled command holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command) &&
		$stable(column) && $stable(glyph_index) && $stable(last))
		else $error("output command changed while stalled");

	// clear carries zero column/glyph and always ends its byte
	a_clear_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (command == CMD_CLEAR) |->
		(column == '0) && (glyph_index == '0) && last)
		else $error("clear command with bad fields");

	// only a draw can be followed by a second command
	a_not_last_is_draw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (command == CMD_DRAW))
		else $error("non-final command is not a draw");

	// the clear after a non-final draw is ready in the very next cycle
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && (command == CMD_CLEAR))
		else $error("second command of a byte missing");

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.command    (command),
	.column     (column),
	.glyph_index(glyph_index),
	.last       (last)
);
`default_nettype wire

// ----- dv/tb_text_console_cursor_scroll.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// Self-checking bench for the text console cursor and scroll block. Bytes go
// in one per transfer; a cursor/ring predictor builds the draw and clear
// commands each byte should cause, and every command transfer is checked
// field by field, in order, against them. Phases vary sender idling and
// receiver stalls, including a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll import tcc_pkg::*; ();

	localparam int COLUMNS    = COLUMNS_DEF;
	localparam int ROWS       = ROWS_DEF;
	localparam int SETTLE_CYC = 16;     // extra wait after draining; leave margin
	localparam int DRAIN_MAX  = 20000;  // cycle limit on waiting for results
	localparam int MAX_PRINT  = 100;    // mismatch lines printed before going quiet

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [CHAR_W-1:0]      char_code;
	logic                   out_valid;
	logic                   out_ready;
	logic                   command;
	logic [SLOT_PORT_W-1:0] row_slot;
	logic [COL_PORT_W-1:0]  column;
	logic [GLYPH_W-1:0]     glyph_index;
	logic [SLOT_PORT_W-1:0] top_slot;
	logic                   last;

	// Traffic shaping, percent of cycles: sender idle / receiver stalled.
	int idle_pct;
	int stall_pct;
	// Receiver hold-off, counted down in the receiver process.
	int hold_off;
	int mismatches;

	// Predicted console state: cursor cell and ring base over ROWS+1 slots.
	logic [6:0] cur_col;
	logic [4:0] cur_row;
	logic [5:0] ring_base;
	// Commands predicted but not yet seen on the output, oldest first.
	cmd_t       pending_cmds[$];

	text_console_cursor_scroll #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.command    (command),
		.row_slot   (row_slot),
		.column     (column),
		.glyph_index(glyph_index),
		.top_slot   (top_slot),
		.last       (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Physical slot showing screen row r: (ring_base + r) mod (ROWS+1).
	function automatic logic [5:0] slot_of_row(input int r);
		int s;
		s = int'(ring_base) + r;
		if (s >= ROWS + 1)
			s -= ROWS + 1;
		return s[5:0];
	endfunction

	function automatic cmd_t make_cmd(input logic cmd, input logic [5:0] slot,
		input logic [6:0] col, input logic [7:0] glyph, input logic [5:0] top,
		input logic fin);
		cmd_t c;
		c.command     = cmd;
		c.row_slot    = slot;
		c.column      = col;
		c.glyph_index = glyph;
		c.top_slot    = top;
		c.last        = fin;
		return c;
	endfunction

	// Cursor to column 0 of the next row. On the bottom row the screen scrolls
	// instead: the top slot is handed back for clearing and the ring advances.
	function automatic bit start_new_line(output logic [5:0] cleared);
		cleared = '0;
		cur_col = '0;
		if (int'(cur_row) < ROWS - 1) begin
			cur_row++;
			return 1'b0;
		end
		cleared   = ring_base;
		ring_base = slot_of_row(1);
		return 1'b1;
	endfunction

	// Queue the commands one accepted byte causes and update the cursor.
	function automatic void predict_byte(input logic [7:0] c);
		logic [5:0] cleared;
		logic [5:0] slot;
		logic [6:0] col;
		bit         scrolled;
		if (c <= CTRL_LOW_MAX || (c >= CTRL_HIGH_MIN && c <= CTRL_HIGH_MAX)) begin
			// only line feed does anything; it shows only if it scrolls
			if (c == CHAR_LF) begin
				if (start_new_line(cleared))
					pending_cmds.push_back(make_cmd(CMD_CLEAR, cleared, '0, '0,
						ring_base, 1'b1));
			end
			return;
		end
		slot     = slot_of_row(int'(cur_row));
		col      = cur_col;
		scrolled = 1'b0;
		if (int'(cur_col) + 1 >= COLUMNS)
			scrolled = start_new_line(cleared);
		else
			cur_col++;
		if (scrolled) begin
			// draw still reports the top slot from before the scroll
			pending_cmds.push_back(make_cmd(CMD_DRAW, slot, col, c - GLYPH_OFFSET,
				cleared, 1'b0));
			pending_cmds.push_back(make_cmd(CMD_CLEAR, cleared, '0, '0,
				ring_base, 1'b1));
		end else begin
			pending_cmds.push_back(make_cmd(CMD_DRAW, slot, col, c - GLYPH_OFFSET,
				ring_base, 1'b1));
		end
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINT)
			$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// Output values are sampled before this edge's updates land, so the
	// transfer seen here is the one that completes at this edge.
	always @(posedge clk) begin : result_check
		cmd_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch($sformatf("unexpected command %0d slot %0d col %0d",
					command, row_slot, column));
			end else begin
				want = pending_cmds.pop_front();
				check_field("command",     32'(command),     32'(want.command));
				check_field("row_slot",    32'(row_slot),    32'(want.row_slot));
				check_field("column",      32'(column),      32'(want.column));
				check_field("glyph_index", 32'(glyph_index), 32'(want.glyph_index));
				check_field("top_slot",    32'(top_slot),    32'(want.top_slot));
				check_field("last",        32'(last),        32'(want.last));
			end
		end
	end

	// Receiver: long hold-off when asked, otherwise random stalls.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// One byte transfer. Idle cycles go before valid rises; valid is not
	// lowered after the transfer, so back-to-back bytes keep it high.
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		do
			@(posedge clk);
		while (!in_ready);
		predict_byte(c);
	endtask

	// Mostly printable text with line feeds, so lines wrap and the screen
	// scrolls often; the rest is any byte at all.
	function automatic logic [7:0] pick_char();
		int r;
		int v;
		r = $urandom_range(99);
		if (r < 70) begin
			v = $urandom_range(190);
			return (v < 95) ? 8'(8'h20 + v) : 8'(8'hA0 + v - 95);
		end
		if (r < 85)
			return CHAR_LF;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_printable();
		int v;
		v = $urandom_range(190);
		return (v < 95) ? 8'(8'h20 + v) : 8'(8'hA0 + v - 95);
	endfunction

	task automatic send_random(input int n);
		repeat (n) send_char(pick_char());
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		while (pending_cmds.size() != 0 && n < DRAIN_MAX) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_traffic(input int idle, input int stall);
		idle_pct  = idle;
		stall_pct = stall;
	endtask

	// Range edges of the byte and the control/printable boundaries, plus a
	// line feed well above the bottom row.
	task automatic test_char_extremes();
		logic [7:0] chars[$];
		set_traffic(0, 0);
		chars = '{8'h00, 8'h1F, 8'h20, 8'h21, 8'h7E, 8'h7F, 8'h80, 8'h9F,
			8'hA0, 8'hFF, CHAR_LF, 8'h55, 8'hAA};
		foreach (chars[i])
			send_char(chars[i]);
	endtask

	// Walk down to the bottom row, then a line feed there must scroll.
	task automatic test_bottom_line_feed();
		while (int'(cur_row) < ROWS - 1)
			send_char(CHAR_LF);
		send_char(CHAR_LF);
		send_char(pick_printable());
	endtask

	// Fill the bottom line: the last cell gives a draw and then a clear.
	task automatic test_bottom_wrap();
		while (int'(cur_col) != COLUMNS - 1)
			send_char(pick_printable());
		send_char(pick_printable());
		send_char(8'hFF);
	endtask

	task automatic test_no_idle();
		set_traffic(0, 0);
		send_random(450);
	endtask

	task automatic test_sender_idle();
		set_traffic(82, 0);
		send_random(400);
	endtask

	task automatic test_receiver_stall();
		set_traffic(0, 82);
		send_random(400);
	endtask

	task automatic test_both_idle();
		set_traffic(12, 12);
		send_random(400);
	endtask

	// Receiver holds off for a long stretch while bytes keep coming, so the
	// block fills and must drop in_ready.
	task automatic test_backpressure();
		set_traffic(0, 0);
		hold_off = 300;
		send_random(150);
	endtask

	// Sender stops until every expected command is out, then resumes.
	task automatic test_pause_until_drained();
		set_traffic(12, 40);
		send_random(40);
		in_valid <= 1'b0;
		wait_drained();
		send_random(40);
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		char_code  = '0;
		out_ready  = 1'b0;
		idle_pct   = 0;
		stall_pct  = 0;
		hold_off   = 0;
		mismatches = 0;
		cur_col    = '0;
		cur_row    = '0;
		ring_base  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_char_extremes();
		test_bottom_line_feed();
		test_bottom_wrap();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		test_pause_until_drained();

		in_valid <= 1'b0;
		set_traffic(0, 0);
		wait_drained();
		if (pending_cmds.size() != 0)
			report_mismatch($sformatf("%0d expected commands never came",
				pending_cmds.size()));

		if (mismatches == 0)
			$display("[text_console_cursor_scroll] OK");
		else
			$display("[text_console_cursor_scroll] ERROR");
		$finish;
	end

	// Normal runs end far before this limit.
	initial begin
		#2000000;
		$display("TIMEOUT at %0t ns", $time);
		$display("[text_console_cursor_scroll] ERROR");
		$finish;
	end

endmodule
